// ===== src/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and helpers for the path tangent and curvature unit
// Payload structs, register indexes, sequencer states and lane helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;

  localparam logic [23:0] CURV_MAX = 24'h7F_FFFF;
  localparam logic [14:0] TAN_ONE  = 15'd16384;

  // configuration register indexes
  localparam logic [2:0] CFG_START_POS = 3'd0;
  localparam logic [2:0] CFG_START_DIR = 3'd1;
  localparam logic [2:0] CFG_END_POS   = 3'd2;
  localparam logic [2:0] CFG_END_DIR   = 3'd3;
  localparam logic [2:0] CFG_ARC_LEN   = 3'd4;
  localparam logic [2:0] CFG_NUM_SEG   = 3'd5;
  localparam logic [2:0] CFG_CURV_MODE = 3'd6;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } ptc_in_t;

  typedef struct packed {
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [23:0] curvature;
    logic               curvature_valid;
    logic        [10:0] tangent_index;
    logic               last;
  } ptc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DS,
    ST_V1,
    ST_DIFF,
    ST_SQ,
    ST_NROOT,
    ST_NDIV,
    ST_TAN,
    ST_CURV,
    ST_CNA,
    ST_DOT,
    ST_CROOT,
    ST_CDIV,
    ST_EMIT1,
    ST_EMIT2
  } ptc_state_t;

  // 16-bit lane of a packed x,y,z word, x in the low bits
  function automatic logic signed [15:0] lane16(input logic [47:0] v, input logic [1:0] i);
    logic signed [15:0] r;
    case (i)
      2'd0:    r = v[15:0];
      2'd1:    r = v[31:16];
      default: r = v[47:32];
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] lane18(input logic [53:0] v, input logic [1:0] i);
    logic signed [17:0] r;
    case (i)
      2'd0:    r = v[17:0];
      2'd1:    r = v[35:18];
      default: r = v[53:36];
    endcase
    return r;
  endfunction

  function automatic logic [47:0] set16(input logic [47:0] v, input logic [1:0] i,
                                        input logic [15:0] x);
    logic [47:0] r;
    r = v;
    case (i)
      2'd0:    r[15:0]  = x;
      2'd1:    r[31:16] = x;
      default: r[47:32] = x;
    endcase
    return r;
  endfunction

  // sign-extended difference b - a of two packed 16-bit vectors
  function automatic logic [53:0] diff3(input logic [47:0] b, input logic [47:0] a);
    logic [53:0] r;
    for (int i = 0; i < 3; i++) begin
      r[i*18 +: 18] = 18'(signed'(b[i*16 +: 16])) - 18'(signed'(a[i*16 +: 16]));
    end
    return r;
  endfunction

  function automatic logic [53:0] sext3(input logic [47:0] a);
    logic [53:0] r;
    for (int i = 0; i < 3; i++) begin
      r[i*18 +: 18] = 18'(signed'(a[i*16 +: 16]));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/polyline_tangent_curvature.sv =====
// ----------------------------------------------------------------------------
// polyline_tangent_curvature: unit tangents and curvature along a sampled path
// Takes one vertex per request, emits the normalized segment tangent with the
// curvature against the previous tangent, and the end direction at the path end.
// ----------------------------------------------------------------------------
// Vertex 0 runs the 24-step divider for the segment length and gives no result.
// Other vertices normalize their segment for the tangent (vertex 1 first
// normalizes the start direction), then work a mode 0 or a mode 1 curvature;
// the final vertex adds a second curvature. One vertex is worked at a time, on
// the shared square root (31 steps, one root bit a cycle) and divider (one
// quotient bit a cycle).
// Synchronous active-low reset clears the sequencer, the vertex count and the
// configuration registers to their defaults; a result waiting in the output register is lost.
`default_nettype none

module polyline_tangent_curvature #(
  parameter int MAX_SEGMENTS = ptc_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ptc_pkg::ptc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ptc_pkg::ptc_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [47:0]       cfg_data
);

  // configuration
  logic [47:0] cfg_sp_r, cfg_sd_r, cfg_ep_r, cfg_ed_r;
  logic [15:0] cfg_arc_r;
  logic [10:0] cfg_nseg_r;
  logic        cfg_mode_r;

  // sequencer
  ptc_pkg::ptc_state_t state_r, state_nxt, nret_r, nret_nxt, cret_r, cret_nxt;
  logic [10:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic        final_r, final_nxt, sq_norm_r, sq_norm_nxt;
  logic [1:0]  k_r, k_nxt;

  // datapath
  logic [23:0] ds_r, ds_nxt, curv_r, curv_nxt;
  logic [47:0] pv_r, pv_nxt, pt_r, pt_nxt, p_r, p_nxt, tan_r, tan_nxt;
  logic [47:0] ca_r, ca_nxt, cb_r, cb_nxt, na_r, na_nxt, nrm_r, nrm_nxt;
  logic [53:0] vec_r, vec_nxt;
  logic signed [42:0] prod_r, prod_nxt;
  logic signed [37:0] acc_r, acc_nxt;

  // square root, two radicand bits per step
  logic [61:0] sq_rad_r, sq_rad_nxt;
  logic [33:0] sq_rem_r, sq_rem_nxt;
  logic [30:0] sq_root_r, sq_root_nxt;
  logic [4:0]  sq_cnt_r, sq_cnt_nxt;
  logic        sq_busy_r, sq_busy_nxt;

  // restoring divider, one quotient bit per step
  logic [31:0] dv_rem_r, dv_rem_nxt;
  logic [33:0] dv_dsr_r, dv_dsr_nxt, dv_q_r, dv_q_nxt;
  logic [30:0] dv_div_r, dv_div_nxt;
  logic [5:0]  dv_cnt_r, dv_cnt_nxt;
  logic        dv_busy_r, dv_busy_nxt;

  logic              out_valid_r, out_valid_nxt;
  ptc_pkg::ptc_out_t out_data_r, out_data_nxt;

  // helpers
  logic [10:0] n_eff;
  logic [1:0]  j, jm, kn;
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [37:0] acc_sum;
  logic [42:0] prod_mag;
  logic [16:0] v1_rnd;
  logic signed [18:0] v1_off, v1_sum;
  logic [15:0] v1_lane;
  logic [37:0] dot_mag;
  logic [23:0] dot_rnd, dot_val;
  logic signed [17:0] vl_k, vl_kn;
  logic [17:0] vmag_kn, vmag_0;
  logic [14:0] nq;
  logic [15:0] nq_s;
  logic        out_free, accept;
  logic [33:0] sq_sh, sq_trial;
  logic [32:0] dv_sh, dv_cmp;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ptc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (cfg_nseg_r == 11'd0) begin
      n_eff = 11'd1;
    end else if (int'(cfg_nseg_r) > MAX_SEGMENTS) begin
      n_eff = 11'(MAX_SEGMENTS);
    end else begin
      n_eff = cfg_nseg_r;
    end
  end

  assign j  = (k_r == 2'd3) ? 2'd2 : k_r;
  assign jm = k_r - 2'd1;
  assign kn = k_r + 2'd1;

  // shared multiplier operands
  always_comb begin
    case (state_r)
      ptc_pkg::ST_V1: begin
        mul_a = signed'({1'b0, ds_r});
        mul_b = 18'(ptc_pkg::lane16(nrm_r, j));
      end
      ptc_pkg::ST_SQ: begin
        mul_a = 25'(ptc_pkg::lane18(vec_r, j));
        mul_b = ptc_pkg::lane18(vec_r, j);
      end
      ptc_pkg::ST_DOT: begin
        mul_a = 25'(ptc_pkg::lane16(na_r, j));
        mul_b = 18'(ptc_pkg::lane16(nrm_r, j));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_sum = ((k_r == 2'd1) ? 38'sd0 : acc_r) + 38'(prod_r);

  // vertex 1 lane: start + round(ds * u / 2^22), saturated
  assign prod_mag = prod_r[42] ? (~prod_r + 43'd1) : prod_r;
  assign v1_rnd   = 17'((prod_mag + 43'd2097152) >> 22);
  assign v1_off   = prod_r[42] ? -signed'({2'b00, v1_rnd}) : signed'({2'b00, v1_rnd});
  assign v1_sum   = 19'(ptc_pkg::lane16(cfg_sp_r, jm)) + v1_off;
  always_comb begin
    if (v1_sum > 19'sd32767) begin
      v1_lane = 16'h7FFF;
    end else if (v1_sum < -19'sd32768) begin
      v1_lane = 16'h8000;
    end else begin
      v1_lane = v1_sum[15:0];
    end
  end

  // dot product rounding, half away from zero
  assign dot_mag = acc_sum[37] ? (~acc_sum + 38'd1) : acc_sum;
  assign dot_rnd = 24'((dot_mag + 38'd8192) >> 14);
  assign dot_val = acc_sum[37] ? (~dot_rnd + 24'd1) : dot_rnd;

  // normalize lanes
  assign vl_k    = ptc_pkg::lane18(vec_r, k_r);
  assign vl_kn   = ptc_pkg::lane18(vec_r, kn);
  assign vmag_kn = vl_kn[17] ? (~vl_kn + 18'd1) : vl_kn;
  assign vmag_0  = vec_r[17] ? (~vec_r[17:0] + 18'd1) : vec_r[17:0];
  assign nq      = (dv_q_r[14:0] > ptc_pkg::TAN_ONE) ? ptc_pkg::TAN_ONE : dv_q_r[14:0];
  assign nq_s    = vl_k[17] ? (~{1'b0, nq} + 16'd1) : {1'b0, nq};

  assign sq_sh    = {sq_rem_r[31:0], sq_rad_r[61:60]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign dv_sh    = {dv_rem_r, dv_dsr_r[33]};
  assign dv_cmp   = {2'b00, dv_div_r};

  always_comb begin
    state_nxt = state_r;  nret_nxt = nret_r;  cret_nxt = cret_r;
    cnt_nxt = cnt_r;  idx_nxt = idx_r;  final_nxt = final_r;
    sq_norm_nxt = sq_norm_r;  k_nxt = k_r;
    ds_nxt = ds_r;  curv_nxt = curv_r;  pv_nxt = pv_r;  pt_nxt = pt_r;
    p_nxt = p_r;  tan_nxt = tan_r;  ca_nxt = ca_r;  cb_nxt = cb_r;
    na_nxt = na_r;  nrm_nxt = nrm_r;  vec_nxt = vec_r;
    prod_nxt = mul_a * mul_b;
    acc_nxt = acc_r;
    sq_rad_nxt = sq_rad_r;  sq_rem_nxt = sq_rem_r;  sq_root_nxt = sq_root_r;
    sq_cnt_nxt = sq_cnt_r;  sq_busy_nxt = sq_busy_r;
    dv_rem_nxt = dv_rem_r;  dv_dsr_nxt = dv_dsr_r;  dv_q_nxt = dv_q_r;
    dv_div_nxt = dv_div_r;  dv_cnt_nxt = dv_cnt_r;  dv_busy_nxt = dv_busy_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;

    if (sq_busy_r) begin
      sq_rad_nxt = {sq_rad_r[59:0], 2'b00};
      if (sq_sh >= sq_trial) begin
        sq_rem_nxt  = sq_sh - sq_trial;
        sq_root_nxt = {sq_root_r[29:0], 1'b1};
      end else begin
        sq_rem_nxt  = sq_sh;
        sq_root_nxt = {sq_root_r[29:0], 1'b0};
      end
      sq_cnt_nxt  = sq_cnt_r - 5'd1;
      sq_busy_nxt = (sq_cnt_r != 5'd0);
    end

    if (dv_busy_r) begin
      dv_dsr_nxt = {dv_dsr_r[32:0], 1'b0};
      if (dv_sh >= dv_cmp) begin
        dv_rem_nxt = 32'(dv_sh - dv_cmp);
        dv_q_nxt   = {dv_q_r[32:0], 1'b1};
      end else begin
        dv_rem_nxt = dv_sh[31:0];
        dv_q_nxt   = {dv_q_r[32:0], 1'b0};
      end
      dv_cnt_nxt  = dv_cnt_r - 6'd1;
      dv_busy_nxt = (dv_cnt_r != 6'd0);
    end

    case (state_r)
      ptc_pkg::ST_IDLE: begin
        if (accept) begin
          idx_nxt   = cnt_r;
          final_nxt = (cnt_r >= n_eff);
          if (cnt_r == 11'd0) begin
            dv_rem_nxt  = '0;
            dv_dsr_nxt  = {cfg_arc_r, 18'd0};
            dv_q_nxt    = '0;
            dv_div_nxt  = 31'(n_eff);
            dv_cnt_nxt  = 6'd23;
            dv_busy_nxt = 1'b1;
            state_nxt   = ptc_pkg::ST_DS;
          end else if (cnt_r >= n_eff) begin
            p_nxt     = cfg_ep_r;
            state_nxt = ptc_pkg::ST_DIFF;
          end else if (cnt_r == 11'd1) begin
            vec_nxt     = ptc_pkg::sext3(cfg_sd_r);
            nret_nxt    = ptc_pkg::ST_V1;
            sq_norm_nxt = 1'b1;
            k_nxt       = 2'd0;
            state_nxt   = ptc_pkg::ST_SQ;
          end else begin
            p_nxt     = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
            state_nxt = ptc_pkg::ST_DIFF;
          end
        end
      end
      ptc_pkg::ST_DS: begin
        if (!dv_busy_r) begin
          ds_nxt    = dv_q_r[23:0];
          pv_nxt    = cfg_sp_r;
          cnt_nxt   = 11'd1;
          state_nxt = ptc_pkg::ST_IDLE;
        end
      end
      ptc_pkg::ST_V1: begin
        k_nxt = k_r + 2'd1;
        if (k_r != 2'd0) begin
          p_nxt = ptc_pkg::set16(p_r, jm, v1_lane);
        end
        if (k_r == 2'd3) begin
          state_nxt = ptc_pkg::ST_DIFF;
        end
      end
      ptc_pkg::ST_DIFF: begin
        vec_nxt     = ptc_pkg::diff3(p_r, pv_r);
        nret_nxt    = ptc_pkg::ST_TAN;
        sq_norm_nxt = 1'b1;
        k_nxt       = 2'd0;
        state_nxt   = ptc_pkg::ST_SQ;
      end
      ptc_pkg::ST_SQ: begin
        k_nxt = k_r + 2'd1;
        if (k_r != 2'd0) begin
          acc_nxt = acc_sum;
        end
        if (k_r == 2'd3) begin
          if (sq_norm_r) begin
            if (acc_sum == 38'sd0) begin
              nrm_nxt   = '0;
              k_nxt     = 2'd0;
              state_nxt = nret_r;
            end else begin
              sq_rad_nxt  = 62'(acc_sum[35:0]) << 24;
              sq_rem_nxt  = '0;
              sq_root_nxt = '0;
              sq_cnt_nxt  = 5'd30;
              sq_busy_nxt = 1'b1;
              state_nxt   = ptc_pkg::ST_NROOT;
            end
          end else begin
            if (ds_r == 24'd0) begin
              curv_nxt  = (acc_sum == 38'sd0) ? 24'd0 : ptc_pkg::CURV_MAX;
              state_nxt = cret_r;
            end else begin
              sq_rad_nxt  = 62'(acc_sum[35:0]) << 16;
              sq_rem_nxt  = '0;
              sq_root_nxt = '0;
              sq_cnt_nxt  = 5'd30;
              sq_busy_nxt = 1'b1;
              state_nxt   = ptc_pkg::ST_CROOT;
            end
          end
        end
      end
      ptc_pkg::ST_NROOT: begin
        if (!sq_busy_r) begin
          dv_rem_nxt  = 32'({vmag_0, 11'd0});
          dv_dsr_nxt  = '0;
          dv_q_nxt    = '0;
          dv_div_nxt  = sq_root_r;
          dv_cnt_nxt  = 6'd14;
          dv_busy_nxt = 1'b1;
          k_nxt       = 2'd0;
          state_nxt   = ptc_pkg::ST_NDIV;
        end
      end
      ptc_pkg::ST_NDIV: begin
        if (!dv_busy_r) begin
          nrm_nxt = ptc_pkg::set16(nrm_r, k_r, nq_s);
          if (k_r == 2'd2) begin
            k_nxt     = 2'd0;
            state_nxt = nret_r;
          end else begin
            // next lane divides by the same root
            dv_rem_nxt  = 32'({vmag_kn, 11'd0});
            dv_dsr_nxt  = '0;
            dv_q_nxt    = '0;
            dv_cnt_nxt  = 6'd14;
            dv_busy_nxt = 1'b1;
            k_nxt       = kn;
          end
        end
      end
      ptc_pkg::ST_TAN: begin
        tan_nxt = nrm_r;
        if (idx_r >= 11'd2) begin
          ca_nxt    = pt_r;
          cb_nxt    = nrm_r;
          cret_nxt  = ptc_pkg::ST_EMIT1;
          state_nxt = ptc_pkg::ST_CURV;
        end else begin
          curv_nxt  = '0;
          state_nxt = ptc_pkg::ST_EMIT1;
        end
      end
      ptc_pkg::ST_CURV: begin
        k_nxt     = 2'd0;
        state_nxt = ptc_pkg::ST_SQ;
        if (!cfg_mode_r) begin
          vec_nxt     = ptc_pkg::diff3(cb_r, ca_r);
          sq_norm_nxt = 1'b0;
        end else begin
          vec_nxt     = ptc_pkg::sext3(ca_r);
          nret_nxt    = ptc_pkg::ST_CNA;
          sq_norm_nxt = 1'b1;
        end
      end
      ptc_pkg::ST_CNA: begin
        na_nxt      = nrm_r;
        vec_nxt     = ptc_pkg::sext3(cb_r);
        nret_nxt    = ptc_pkg::ST_DOT;
        sq_norm_nxt = 1'b1;
        k_nxt       = 2'd0;
        state_nxt   = ptc_pkg::ST_SQ;
      end
      ptc_pkg::ST_DOT: begin
        k_nxt = k_r + 2'd1;
        if (k_r != 2'd0) begin
          acc_nxt = acc_sum;
        end
        if (k_r == 2'd3) begin
          curv_nxt  = dot_val;
          state_nxt = cret_r;
        end
      end
      ptc_pkg::ST_CROOT: begin
        if (!sq_busy_r) begin
          dv_rem_nxt  = '0;
          dv_dsr_nxt  = {sq_root_r[25:0], 8'd0};
          dv_q_nxt    = '0;
          dv_div_nxt  = 31'(ds_r);
          dv_cnt_nxt  = 6'd33;
          dv_busy_nxt = 1'b1;
          state_nxt   = ptc_pkg::ST_CDIV;
        end
      end
      ptc_pkg::ST_CDIV: begin
        if (!dv_busy_r) begin
          curv_nxt  = (dv_q_r > 34'(ptc_pkg::CURV_MAX)) ? ptc_pkg::CURV_MAX : dv_q_r[23:0];
          state_nxt = cret_r;
        end
      end
      ptc_pkg::ST_EMIT1: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.tan_x           = ptc_pkg::lane16(tan_r, 2'd0);
          out_data_nxt.tan_y           = ptc_pkg::lane16(tan_r, 2'd1);
          out_data_nxt.tan_z           = ptc_pkg::lane16(tan_r, 2'd2);
          out_data_nxt.curvature       = curv_r;
          out_data_nxt.curvature_valid = (idx_r >= 11'd2);
          out_data_nxt.tangent_index   = idx_r - 11'd1;
          out_data_nxt.last            = 1'b0;
          pt_nxt = tan_r;
          pv_nxt = p_r;
          if (!final_r) begin
            cnt_nxt   = cnt_r + 11'd1;
            state_nxt = ptc_pkg::ST_IDLE;
          end else begin
            ca_nxt    = tan_r;
            cb_nxt    = cfg_ed_r;
            cret_nxt  = ptc_pkg::ST_EMIT2;
            state_nxt = ptc_pkg::ST_CURV;
          end
        end
      end
      ptc_pkg::ST_EMIT2: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.tan_x           = ptc_pkg::lane16(cfg_ed_r, 2'd0);
          out_data_nxt.tan_y           = ptc_pkg::lane16(cfg_ed_r, 2'd1);
          out_data_nxt.tan_z           = ptc_pkg::lane16(cfg_ed_r, 2'd2);
          out_data_nxt.curvature       = curv_r;
          out_data_nxt.curvature_valid = 1'b1;
          out_data_nxt.tangent_index   = idx_r;
          out_data_nxt.last            = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ptc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ptc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptc_pkg::ST_IDLE;
      nret_r      <= ptc_pkg::ST_IDLE;
      cret_r      <= ptc_pkg::ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      sq_busy_r   <= 1'b0;
      dv_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ds_r        <= '0;
      pv_r        <= '0;
      pt_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      nret_r      <= nret_nxt;
      cret_r      <= cret_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      sq_busy_r   <= sq_busy_nxt;
      dv_busy_r   <= dv_busy_nxt;
      out_valid_r <= out_valid_nxt;
      ds_r        <= ds_nxt;
      pv_r        <= pv_nxt;
      pt_r        <= pt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    final_r    <= final_nxt;
    sq_norm_r  <= sq_norm_nxt;
    curv_r     <= curv_nxt;
    p_r        <= p_nxt;
    tan_r      <= tan_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    na_r       <= na_nxt;
    nrm_r      <= nrm_nxt;
    vec_r      <= vec_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    sq_rad_r   <= sq_rad_nxt;
    sq_rem_r   <= sq_rem_nxt;
    sq_root_r  <= sq_root_nxt;
    sq_cnt_r   <= sq_cnt_nxt;
    dv_rem_r   <= dv_rem_nxt;
    dv_dsr_r   <= dv_dsr_nxt;
    dv_q_r     <= dv_q_nxt;
    dv_div_r   <= dv_div_nxt;
    dv_cnt_r   <= dv_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sp_r   <= '0;
      cfg_sd_r   <= 48'd16384;
      cfg_ep_r   <= '0;
      cfg_ed_r   <= 48'd16384;
      cfg_arc_r  <= 16'd256;
      cfg_nseg_r <= 11'd1;
      cfg_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptc_pkg::CFG_START_POS: cfg_sp_r   <= cfg_data;
        ptc_pkg::CFG_START_DIR: cfg_sd_r   <= cfg_data;
        ptc_pkg::CFG_END_POS:   cfg_ep_r   <= cfg_data;
        ptc_pkg::CFG_END_DIR:   cfg_ed_r   <= cfg_data;
        ptc_pkg::CFG_ARC_LEN:   cfg_arc_r  <= cfg_data[15:0];
        ptc_pkg::CFG_NUM_SEG:   cfg_nseg_r <= cfg_data[10:0];
        ptc_pkg::CFG_CURV_MODE: cfg_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // root and divider share the sequencer and never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sq_busy_r && dv_busy_r))
    else $error("square root and divider busy together");

  // a new result only comes from one of the two emit states
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ptc_pkg::ST_EMIT1 ||
                            $past(state_r) == ptc_pkg::ST_EMIT2))
    else $error("result loaded outside an emit state");

  // the end-direction result belongs to a final vertex only
  a_emit2_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptc_pkg::ST_EMIT2) |-> final_r)
    else $error("end direction emitted for a non-final vertex");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the polyline tangent and curvature unit
// Drives path vertices through the stall handshake and reprograms the
// registers between phases. Results are checked against a local fixed-point
// predictor of the tangent and curvature arithmetic or typed expected values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1000;
  localparam int CALM_FROM    = 850;
  localparam int SETTLE       = 64;
  localparam int LONG_HOLD    = 1500;
  localparam int CYCLE_LIMIT  = 4000000;

  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [47:0]        val;
    ptc_pkg::ptc_in_t   pos;
    int                 typed_n;
    ptc_pkg::ptc_out_t  t0;
    ptc_pkg::ptc_out_t  t1;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ptc_pkg::ptc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ptc_pkg::ptc_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  polyline_tangent_curvature dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // register shadow and path state of the predictor
  logic [47:0] sh_start_pos = 48'd0;
  logic [47:0] sh_start_dir = 48'd16384;
  logic [47:0] sh_end_pos   = 48'd0;
  logic [47:0] sh_end_dir   = 48'd16384;
  logic [15:0] sh_arc_len   = 16'd256;
  logic [10:0] sh_num_seg   = 11'd1;
  logic        sh_mode      = 1'b0;
  int          vtx_count    = 0;
  logic [47:0] last_vertex  = 48'd0;
  logic [47:0] last_tangent = 48'd0;
  longint unsigned seg_len  = 0;

  ptc_pkg::ptc_out_t tangent_q[$];
  stim_row_t stim_rows[$];
  int        errors  = 0;
  int        cycles  = 0;
  bit        hold_req = 1'b0;
  bit        calm     = 1'b0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint lane(input logic [47:0] p, input int i);
    return longint'(signed'(p[i*16 +: 16]));
  endfunction

  function automatic longint shr_round(input longint x, input int s);
    longint m;
    m = x < 0 ? -x : x;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return x < 0 ? -m : m;
  endfunction

  function automatic logic [47:0] pack_vec(input longint t[3]);
    logic [15:0] a, b, c;
    a = t[0][15:0];
    b = t[1][15:0];
    c = t[2][15:0];
    return {c, b, a};
  endfunction

  task automatic unit_vec(input longint v[3], output longint t[3]);
    longint unsigned m2, r, a, q;
    m2 = 0;
    for (int i = 0; i < 3; i++) m2 += longint'(v[i] * v[i]);
    if (m2 == 0) begin
      t[0] = 0;
      t[1] = 0;
      t[2] = 0;
      return;
    end
    r = int_sqrt(m2 << 24);
    for (int i = 0; i < 3; i++) begin
      a = v[i] < 0 ? -v[i] : v[i];
      q = (a << 26) / r;
      if (q > 16384) q = 16384;
      t[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic bend(input logic [47:0] lt, input logic [47:0] rt, output longint c);
    longint a[3], b[3], na[3], nb[3], d, dot;
    longint unsigned s, q;
    for (int i = 0; i < 3; i++) begin
      a[i] = lane(lt, i);
      b[i] = lane(rt, i);
    end
    if (sh_mode) begin
      unit_vec(a, na);
      unit_vec(b, nb);
      dot = 0;
      for (int i = 0; i < 3; i++) dot += na[i] * nb[i];
      c = shr_round(dot, 14);
      return;
    end
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d = b[i] - a[i];
      s += longint'(d * d);
    end
    if (seg_len == 0) begin
      c = (s == 0) ? 0 : 8388607;
      return;
    end
    q = (int_sqrt(s << 16) << 8) / seg_len;
    c = (q > 8388607) ? 8388607 : longint'(q);
  endtask

  // advance the path by one vertex and queue the tangents it produces
  task automatic predict_vertex(input ptc_pkg::ptc_in_t item);
    int n, idx;
    bit closing;
    longint p[3], d[3], u[3], t[3], v, c, c2;
    logic [47:0] tan;
    ptc_pkg::ptc_out_t r;
    n = sh_num_seg;
    if (n == 0) n = 1;
    if (n > ptc_pkg::MAX_SEGMENTS_DEF) n = ptc_pkg::MAX_SEGMENTS_DEF;
    idx = vtx_count;
    closing = idx >= n;
    if (idx == 0) begin
      seg_len = (longint'(sh_arc_len) << 8) / n;
      last_vertex = sh_start_pos;
      vtx_count = 1;
      return;
    end
    if (closing) begin
      for (int i = 0; i < 3; i++) p[i] = lane(sh_end_pos, i);
    end else if (idx == 1) begin
      for (int i = 0; i < 3; i++) d[i] = lane(sh_start_dir, i);
      unit_vec(d, u);
      for (int i = 0; i < 3; i++) begin
        v = lane(sh_start_pos, i) + shr_round(longint'(seg_len) * u[i], 22);
        p[i] = v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
      end
    end else begin
      p[0] = item.pos_x;
      p[1] = item.pos_y;
      p[2] = item.pos_z;
    end
    for (int i = 0; i < 3; i++) d[i] = p[i] - lane(last_vertex, i);
    unit_vec(d, t);
    tan = pack_vec(t);
    c = 0;
    if (idx >= 2) bend(last_tangent, tan, c);
    r.tan_x = tan[15:0];
    r.tan_y = tan[31:16];
    r.tan_z = tan[47:32];
    r.curvature = c[23:0];
    r.curvature_valid = (idx >= 2);
    r.tangent_index = 11'(idx - 1);
    r.last = 1'b0;
    tangent_q.push_back(r);
    last_tangent = tan;
    last_vertex = pack_vec(p);
    if (!closing) begin
      vtx_count = idx + 1;
      return;
    end
    bend(tan, sh_end_dir, c2);
    r.tan_x = sh_end_dir[15:0];
    r.tan_y = sh_end_dir[31:16];
    r.tan_z = sh_end_dir[47:32];
    r.curvature = c2[23:0];
    r.curvature_valid = 1'b1;
    r.tangent_index = 11'(idx);
    r.last = 1'b1;
    tangent_q.push_back(r);
    vtx_count = 0;
  endtask

  // valid stays high after acceptance; the caller lowers it or sends again
  task automatic send_vertex(input ptc_pkg::ptc_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_vertex(item);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ptc_pkg::CFG_START_POS: sh_start_pos = val;
      ptc_pkg::CFG_START_DIR: sh_start_dir = val;
      ptc_pkg::CFG_END_POS:   sh_end_pos   = val;
      ptc_pkg::CFG_END_DIR:   sh_end_dir   = val;
      ptc_pkg::CFG_ARC_LEN:   sh_arc_len   = val[15:0];
      ptc_pkg::CFG_NUM_SEG:   sh_num_seg   = val[10:0];
      ptc_pkg::CFG_CURV_MODE: sh_mode      = val[0];
      default: ;
    endcase
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (tangent_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    ptc_pkg::ptc_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (tangent_q.size() == 0) begin
        $error("unexpected result, tangent_index %0d", out_data.tangent_index);
        errors++;
      end else begin
        e = tangent_q.pop_front();
        if (out_data.tan_x !== e.tan_x) begin
          $error("tan_x expected %0d actual %0d", e.tan_x, out_data.tan_x);
          errors++;
        end
        if (out_data.tan_y !== e.tan_y) begin
          $error("tan_y expected %0d actual %0d", e.tan_y, out_data.tan_y);
          errors++;
        end
        if (out_data.tan_z !== e.tan_z) begin
          $error("tan_z expected %0d actual %0d", e.tan_z, out_data.tan_z);
          errors++;
        end
        if (out_data.curvature !== e.curvature) begin
          $error("curvature expected %0d actual %0d", e.curvature, out_data.curvature);
          errors++;
        end
        if (out_data.curvature_valid !== e.curvature_valid) begin
          $error("curvature_valid expected %0d actual %0d", e.curvature_valid,
                 out_data.curvature_valid);
          errors++;
        end
        if (out_data.tangent_index !== e.tangent_index) begin
          $error("tangent_index expected %0d actual %0d", e.tangent_index,
                 out_data.tangent_index);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // receiver stalls, including one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int sent, plen, pick, held, k;
    longint cur[3];
    ptc_pkg::ptc_in_t item;
    logic [47:0] w;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = ptc_pkg::CFG_START_POS;
    cfg_data  = '0;

    // after reset: one-segment path, start and end at the origin
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0,
                          ptc_pkg::ptc_in_t'(48'h1234_5678_9ABC), 0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0), 2,
        ptc_pkg::ptc_out_t'({16'sd0, 16'sd0, 16'sd0, 24'sd0, 1'b0, 11'd0, 1'b0})
      , ptc_pkg::ptc_out_t'({16'sd16384, 16'sd0, 16'sd0, 24'sd16384, 1'b1, 11'd1, 1'b1})});
    // zero arc length
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_ARC_LEN, 48'd0, '0, 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_NUM_SEG, 48'd2, '0, 0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('1),
                          0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0), 1,
        ptc_pkg::ptc_out_t'({16'sd0, 16'sd0, 16'sd0, 24'sd0, 1'b0, 11'd0, 1'b0}), '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0), 2,
        ptc_pkg::ptc_out_t'({16'sd0, 16'sd0, 16'sd0, 24'sd0, 1'b1, 11'd1, 1'b0})
      , ptc_pkg::ptc_out_t'({16'sd16384, 16'sd0, 16'sd0, 24'sd8388607, 1'b1, 11'd2, 1'b1})});
    // extremes, zero start direction, repeated vertex
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_ARC_LEN, 48'd65535, '0, 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_NUM_SEG, 48'd4, '0, 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_START_POS, 48'h8000_7FFF_8000, '0, 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_START_DIR, 48'd0, '0, 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_END_POS, 48'h7FFF_8000_7FFF, '0, 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_END_DIR, 48'hC000_0000_4000, '0, 0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0),
                          0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0),
                          0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0,
                          ptc_pkg::ptc_in_t'({16'sh7FFF, 16'sh8000, 16'sh7FFF}), 0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0,
                          ptc_pkg::ptc_in_t'({16'sh7FFF, 16'sh8000, 16'sh7FFF}), 0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0,
                          ptc_pkg::ptc_in_t'({16'sh8000, 16'sh7FFF, 16'sh0001}), 0, '0, '0});
    // dot product mode, segment count zero
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_CURV_MODE, 48'd1, '0, 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_START_DIR, 48'h0000_4000_4000, '0, 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_NUM_SEG, 48'd0, '0, 0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0),
                          0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0),
                          0, '0, '0});
    // count above the maximum, then lowered mid-path
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_NUM_SEG, 48'd2047, '0, 0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0),
                          0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0),
                          0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0,
                          ptc_pkg::ptc_in_t'({16'sh0100, 16'shFF00, 16'sh0080}), 0, '0, '0});
    stim_rows.push_back('{1'b1, ptc_pkg::CFG_NUM_SEG, 48'd2, '0, 0, '0, '0});
    stim_rows.push_back('{1'b0, ptc_pkg::CFG_START_POS, 48'd0, ptc_pkg::ptc_in_t'('0),
                          0, '0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg) begin
        drain_outputs();
        cfg_put(row.idx, row.val);
        cfg_valid <= 1'b0;
      end else begin
        maybe_gap();
        k = tangent_q.size();
        send_vertex(row.pos);
        if (row.typed_n > 0 || i == 0) begin
          while (tangent_q.size() > k) void'(tangent_q.pop_back());
          if (row.typed_n > 0) tangent_q.push_back(row.t0);
          if (row.typed_n > 1) tangent_q.push_back(row.t1);
        end
      end
    end

    sent = 0;
    held = 0;
    cur[0] = 0;
    cur[1] = 0;
    cur[2] = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_outputs();
      if (sent >= CALM_FROM) calm = 1'b1;
      else calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        cfg_put(ptc_pkg::CFG_START_POS, 48'({$urandom, $urandom}));
      end
      if ($urandom_range(0, 2) == 0) begin
        w = 48'({$urandom, $urandom});
        if ($urandom_range(0, 7) == 0) w = 48'd0;
        cfg_put(ptc_pkg::CFG_START_DIR, w);
      end
      if ($urandom_range(0, 2) == 0) begin
        cfg_put(ptc_pkg::CFG_END_POS, 48'({$urandom, $urandom}));
      end
      if ($urandom_range(0, 2) == 0) begin
        cfg_put(ptc_pkg::CFG_END_DIR, 48'({$urandom, $urandom}));
      end
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        cfg_put(ptc_pkg::CFG_ARC_LEN, pick == 0 ? 48'd65535 : (pick == 1 ? 48'd0 :
                48'($urandom_range(1, 65535))));
      end
      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) w = 48'($urandom_range(1, 6));
        else if (pick < 95) w = 48'($urandom_range(7, 40));
        else if (pick < 97) w = 48'd0;
        else w = 48'($urandom_range(1024, 2047));
        cfg_put(ptc_pkg::CFG_NUM_SEG, w);
      end
      if ($urandom_range(0, 1) == 0) begin
        cfg_put(ptc_pkg::CFG_CURV_MODE, 48'($urandom_range(0, 1)));
      end
      cfg_valid <= 1'b0;

      plen = $urandom_range(3, 30);
      for (int j = 0; j < plen && sent < RANDOM_ITEMS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          for (int i = 0; i < 3; i++) begin
            cur[i] += longint'($urandom_range(0, 1024)) - 512;
            if (cur[i] > 32767) cur[i] = 32767;
            if (cur[i] < -32768) cur[i] = -32768;
          end
        end else if (pick < 85) begin
          for (int i = 0; i < 3; i++) cur[i] = longint'(signed'(16'($urandom)));
        end else if (pick < 93) begin
          // same vertex again: zero-length segment
        end else begin
          for (int i = 0; i < 3; i++) cur[i] = $urandom_range(0, 1) ? 32767 : -32768;
        end
        item.pos_x = cur[0][15:0];
        item.pos_y = cur[1][15:0];
        item.pos_z = cur[2][15:0];
        if (!calm && $urandom_range(0, 40) == 0) drain_outputs();
        else maybe_gap();
        if (held == 0 && sent >= 400) begin
          hold_req = 1'b1;
          held = 1;
        end
        send_vertex(item);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (tangent_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/ptc_pkg.sv
src/polyline_tangent_curvature.sv
tb/tb_top.sv
